// ===== hw/rtl/prm_pkg.sv =====
// package for the two-level median pressure reference
// shared constants, default parameters and the cell control struct
// no dependencies
package prm_pkg;

  // width of the pressure fields and the reference register
  localparam int DATA_W = 32;

  // default parameter values
  localparam int BLOCK_DEF       = 10;
  localparam int HISTORY_DEF     = 10;
  localparam int SAMPLE_BITS_DEF = 32;

  // reference loaded at reset, 101325 Pa in Q24.8
  localparam logic [DATA_W-1:0] RESET_REF = 32'd25939200;

  // control of one sorting cell
  typedef struct packed {
    logic load;   // write data into the cell whose tag matches the key
    logic sort;   // do one odd-even compare-exchange round
    logic phase;  // round parity: 0 pairs even cells with their right neighbor
  } prm_ctrl_t;

endpackage

// ===== hw/rtl/pressure_reference_two_level_median.sv =====
// A sample that does not close a block gives its result in the cycle after the transfer.
// A block-closing sample runs BLOCK odd-even rounds on the block chain, one push and, once
// the history is full, HISTORY rounds on the history chain, then waits for a free output.
// One sample per cycle inside a block while the output does not stall; new samples stall
// until a closing block is done. Reset clears counters and loads the reference with 101325 Pa.
// Stored samples and medians are not cleared; no clearing pass.
module pressure_reference_two_level_median #(
  parameter int BLOCK       = prm_pkg::BLOCK_DEF,
  parameter int HISTORY     = prm_pkg::HISTORY_DEF,
  parameter int SAMPLE_BITS = prm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [prm_pkg::DATA_W-1:0] cfg_reset_reference_i,
  // sample input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [prm_pkg::DATA_W-1:0] pressure_sample_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [prm_pkg::DATA_W-1:0] reference_pressure_o,
  output logic                       block_median_made_o,
  output logic                       history_full_o
);

  localparam int DW     = prm_pkg::DATA_W;
  localparam int VAL_W  = (SAMPLE_BITS < DW) ? SAMPLE_BITS : DW;
  localparam int BLK_TW = $clog2(BLOCK);
  localparam int HIS_TW = $clog2(HISTORY);
  localparam int MAXN   = (BLOCK > HISTORY) ? BLOCK : HISTORY;
  localparam int RND_W  = $clog2(MAXN);
  localparam logic [BLK_TW-1:0] BLK_LAST = BLK_TW'(BLOCK - 1);
  localparam logic [HIS_TW-1:0] HIS_LAST = HIS_TW'(HISTORY - 1);
  localparam logic [RND_W-1:0]  BRND_LAST = RND_W'(BLOCK - 1);
  localparam logic [RND_W-1:0]  HRND_LAST = RND_W'(HISTORY - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BSORT = 5'b00010,
    S_PUSH  = 5'b00100,
    S_HSORT = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [BLK_TW-1:0]   blk_fill_q, blk_fill_d;
  logic [HIS_TW-1:0]   slot_q, slot_d;
  logic                hist_full_q, hist_full_d;
  logic                hist_any_q, hist_any_d;
  logic [RND_W-1:0]    rnd_q, rnd_d;
  logic [DW-1:0]       ref_q, ref_d;

  logic                out_valid_q, out_valid_d;
  logic [DW-1:0]       out_ref_q, out_ref_d;
  logic                out_made_q, out_made_d;
  logic                out_full_q, out_full_d;

  logic                out_free, in_acc, cfg_acc, closing;
  logic [VAL_W-1:0]    sample;
  logic [VAL_W-1:0]    bmed, hmed;
  logic [DW-1:0]       fin_ref;

  prm_pkg::prm_ctrl_t  blk_ctrl, his_ctrl;

  logic [VAL_W-1:0]    blk_val [BLOCK];
  logic [BLK_TW-1:0]   blk_tag [BLOCK];
  logic [VAL_W-1:0]    his_val [HISTORY];
  logic [HIS_TW-1:0]   his_tag [HISTORY];

  // handshakes
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == S_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign closing     = (blk_fill_q == BLK_LAST);
  assign sample      = pressure_sample_i[VAL_W-1:0];

  // block chain
  for (genvar k = 0; k < BLOCK; k++) begin : g_blk
    localparam int LI = (k > 0) ? k - 1 : k;
    localparam int RI = (k < BLOCK - 1) ? k + 1 : k;
    prm_sort_cell #(
      .W(VAL_W), .TAG_W(BLK_TW), .N(BLOCK), .IDX(k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (blk_ctrl),
      .key_i      (blk_fill_q),
      .data_i     (sample),
      .left_val_i (blk_val[LI]),
      .left_tag_i (blk_tag[LI]),
      .right_val_i(blk_val[RI]),
      .right_tag_i(blk_tag[RI]),
      .val_o      (blk_val[k]),
      .tag_o      (blk_tag[k])
    );
  end

  // history chain
  for (genvar k = 0; k < HISTORY; k++) begin : g_his
    localparam int LI = (k > 0) ? k - 1 : k;
    localparam int RI = (k < HISTORY - 1) ? k + 1 : k;
    prm_sort_cell #(
      .W(VAL_W), .TAG_W(HIS_TW), .N(HISTORY), .IDX(k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (his_ctrl),
      .key_i      (slot_q),
      .data_i     (bmed),
      .left_val_i (his_val[LI]),
      .left_tag_i (his_tag[LI]),
      .right_val_i(his_val[RI]),
      .right_tag_i(his_tag[RI]),
      .val_o      (his_val[k]),
      .tag_o      (his_tag[k])
    );
  end

  // middle of the sorted block chain
  if ((BLOCK % 2) == 0) begin : g_bmed_even
    logic [VAL_W:0] bsum;
    assign bsum = {1'b0, blk_val[BLOCK/2-1]} + {1'b0, blk_val[BLOCK/2]};
    assign bmed = bsum[VAL_W:1];
  end else begin : g_bmed_odd
    assign bmed = blk_val[BLOCK/2];
  end

  // middle of the sorted history chain
  if ((HISTORY % 2) == 0) begin : g_hmed_even
    logic [VAL_W:0] hsum;
    assign hsum = {1'b0, his_val[HISTORY/2-1]} + {1'b0, his_val[HISTORY/2]};
    assign hmed = hsum[VAL_W:1];
  end else begin : g_hmed_odd
    assign hmed = his_val[HISTORY/2];
  end

  assign fin_ref = hist_full_q ? DW'(hmed) : ref_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    blk_fill_d  = blk_fill_q;
    slot_d      = slot_q;
    hist_full_d = hist_full_q;
    hist_any_d  = hist_any_q;
    rnd_d       = rnd_q;
    ref_d       = ref_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_ref_d   = out_ref_q;
    out_made_d  = out_made_q;
    out_full_d  = out_full_q;
    blk_ctrl    = '0;
    his_ctrl    = '0;
    blk_ctrl.phase = rnd_q[0];
    his_ctrl.phase = rnd_q[0];

    unique case (state_q)
      S_IDLE: begin
        // register write reaches the reference only before any sample
        if (cfg_acc && (blk_fill_q == '0) && !hist_any_q) begin
          ref_d = cfg_reset_reference_i;
        end
        if (in_acc) begin
          blk_ctrl.load = 1'b1;
          if (!hist_any_q) begin
            ref_d = DW'(sample);
          end
          if (closing) begin
            blk_fill_d = '0;
            rnd_d      = '0;
            state_d    = S_BSORT;
          end else begin
            blk_fill_d  = blk_fill_q + 1'b1;
            out_valid_d = 1'b1;
            out_ref_d   = hist_any_q ? ref_q : DW'(sample);
            out_made_d  = 1'b0;
            out_full_d  = hist_full_q;
          end
        end
      end
      S_BSORT: begin
        blk_ctrl.sort = 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == BRND_LAST) begin
          rnd_d   = '0;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        // block median into the ring slot
        his_ctrl.load = 1'b1;
        ref_d      = DW'(bmed);
        hist_any_d = 1'b1;
        if (slot_q == HIS_LAST) begin
          slot_d      = '0;
          hist_full_d = 1'b1;
        end else begin
          slot_d = slot_q + 1'b1;
        end
        state_d = (hist_full_q || (slot_q == HIS_LAST)) ? S_HSORT : S_FIN;
      end
      S_HSORT: begin
        his_ctrl.sort = 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == HRND_LAST) begin
          rnd_d   = '0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ref_d       = fin_ref;
          out_valid_d = 1'b1;
          out_ref_d   = fin_ref;
          out_made_d  = 1'b1;
          out_full_d  = hist_full_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      blk_fill_q  <= '0;
      slot_q      <= '0;
      hist_full_q <= 1'b0;
      hist_any_q  <= 1'b0;
      rnd_q       <= '0;
      ref_q       <= prm_pkg::RESET_REF;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blk_fill_q  <= blk_fill_d;
      slot_q      <= slot_d;
      hist_full_q <= hist_full_d;
      hist_any_q  <= hist_any_d;
      rnd_q       <= rnd_d;
      ref_q       <= ref_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_ref_q  <= out_ref_d;
    out_made_q <= out_made_d;
    out_full_q <= out_full_d;
  end

  assign out_valid_o          = out_valid_q;
  assign reference_pressure_o = out_ref_q;
  assign block_median_made_o  = out_made_q;
  assign history_full_o       = out_full_q;

  // checks
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == S_IDLE))
    else $error("sample transfer outside idle");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_full_q |=> hist_full_q)
    else $error("history full flag dropped");

  a_made_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (out_made_q && out_valid_q && blk_fill_q == '0))
    else $error("block median result without empty block");

  a_any_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_full_q |-> hist_any_q)
    else $error("full history marked empty");

endmodule

// ===== hw/rtl/prm_sort_cell.sv =====
// one cell of an odd-even transposition sorting chain
// holds one value and its slot tag, exchanges both with a neighbor each round
// depends on prm_pkg
module prm_sort_cell #(
  parameter int W     = 32,
  parameter int TAG_W = 4,
  parameter int N     = 10,
  parameter int IDX   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prm_pkg::prm_ctrl_t ctrl_i,
  input  logic [TAG_W-1:0]   key_i,
  input  logic [W-1:0]       data_i,
  input  logic [W-1:0]       left_val_i,
  input  logic [TAG_W-1:0]   left_tag_i,
  input  logic [W-1:0]       right_val_i,
  input  logic [TAG_W-1:0]   right_tag_i,
  output logic [W-1:0]       val_o,
  output logic [TAG_W-1:0]   tag_o
);

  localparam logic ODD   = ((IDX % 2) == 1);
  localparam logic HAS_L = (IDX > 0);
  localparam logic HAS_R = (IDX < N - 1);

  logic [W-1:0]     val_q, val_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic             pair_r, pair_l, take_r, take_l;

  // partner selection for this round
  assign pair_r = HAS_R && (ctrl_i.phase == ODD);
  assign pair_l = HAS_L && (ctrl_i.phase != ODD);
  assign take_r = pair_r && (right_val_i < val_q);
  assign take_l = pair_l && (left_val_i > val_q);

  // load by tag match, otherwise compare-exchange
  always_comb begin
    val_d = val_q;
    tag_d = tag_q;
    if (ctrl_i.load && (tag_q == key_i)) begin
      val_d = data_i;
    end else if (ctrl_i.sort) begin
      if (take_r) begin
        val_d = right_val_i;
        tag_d = right_tag_i;
      end else if (take_l) begin
        val_d = left_val_i;
        tag_d = left_tag_i;
      end
    end
  end

  // value carries no reset, tags start as a permutation of slot numbers
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= TAG_W'(IDX);
    end else begin
      tag_q <= tag_d;
    end
  end

  assign val_o = val_q;
  assign tag_o = tag_q;

endmodule
